### design/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg: shared types and codes for the double-ended queue
// Operation and status codes, word type and per-cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

    localparam int WORD_W   = 32;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [KIND_W-1:0]        kind_t;
    typedef logic [STATUS_W-1:0]      status_t;

    // operation codes
    localparam kind_t KIND_PUSH_FRONT = 2'd0;
    localparam kind_t KIND_PUSH_REAR  = 2'd1;
    localparam kind_t KIND_POP_FRONT  = 2'd2;
    localparam kind_t KIND_POP_REAR   = 2'd3;

    // status codes
    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_UNDER = 2'd1;
    localparam status_t ST_OVER  = 2'd2;

    // operation broadcast to every cell of the chain (at most one bit set)
    typedef struct packed {
        logic push_front;
        logic push_rear;
        logic pop_front;
        logic pop_rear;
    } ctrl_t;

endpackage

`default_nettype wire

### design/dq_cell.sv
// ----------------------------------------------------------------------------
// dq_cell: one storage cell of the queue chain
// Holds one word and its valid bit; shifts toward either neighbor on a
// front push or pop, fills or drains itself when it sits at the rear end.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire dq_pkg::ctrl_t ctrl,
    input  wire dq_pkg::word_t value,
    input  wire dq_pkg::word_t left_data,
    input  wire logic          left_valid,
    input  wire dq_pkg::word_t right_data,
    input  wire logic          right_valid,
    output dq_pkg::word_t      data,
    output logic               valid,
    output dq_pkg::word_t      rear_tap
);

    dq_pkg::word_t data_reg;
    dq_pkg::word_t data_next;
    logic          valid_reg;
    logic          valid_next;

    // next-state per operation
    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (ctrl.push_front)
        begin
            data_next  = left_data;
            valid_next = left_valid;
        end
        else if (ctrl.pop_front)
        begin
            data_next  = right_data;
            valid_next = right_valid;
        end
        else if (ctrl.push_rear)
        begin
            // first empty cell behind the rear takes the word
            if (!valid_reg && left_valid)
            begin
                data_next  = value;
                valid_next = 1'b1;
            end
        end
        else if (ctrl.pop_rear)
        begin
            if (valid_reg && !right_valid)
            begin
                valid_next = 1'b0;
            end
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign valid    = valid_reg;
    // only the rear cell contributes its word
    assign rear_tap = (valid_reg && !right_valid) ? data_reg : '0;

endmodule

`default_nettype wire

### design/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed 32-bit words
// Chain of DEPTH cells with the front word always in cell 0.
// ----------------------------------------------------------------------------
// Each transaction on the input carries one operation (push front, push
// rear, pop front, pop rear) and yields one result transaction with the
// status and the front word, rear word, count and empty flag after the
// operation. The words live in a row of cells: a front push or pop shifts
// the whole row by one place in the accept cycle, a rear push or pop
// touches only the cell at the rear end. The result is formed from the
// cells in the cycle after accept, while eval_reg is set, and is then
// registered into the outputs as out_valid rises. The input is held off
// during that evaluation cycle, so no new transaction is taken while the
// previous one is evaluated; a new one is accepted once the previous
// result has been taken or is being taken. Empty queue reads 0 at both ends.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [dq_pkg::KIND_W-1:0]       kind,
    input  wire logic signed [dq_pkg::WORD_W-1:0] value,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [dq_pkg::STATUS_W-1:0]          status,
    output logic signed [dq_pkg::WORD_W-1:0]     front_word,
    output logic signed [dq_pkg::WORD_W-1:0]     rear_word,
    output logic [dq_pkg::COUNT_W-1:0]           count,
    output logic                                 empty_res
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                   accept;
    logic                   full;
    logic                   is_empty;
    dq_pkg::ctrl_t          ctrl;
    dq_pkg::status_t        status_next;
    logic [CNT_W-1:0]       fill_reg;
    logic [CNT_W-1:0]       fill_next;
    logic                   eval_reg;
    dq_pkg::status_t        pend_status_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    dq_pkg::status_t        status_reg;
    dq_pkg::word_t          front_reg;
    dq_pkg::word_t          rear_reg;
    logic [CNT_W-1:0]       fill_out_reg;
    logic [CNT_W+dq_pkg::COUNT_W-1:0] fill_wide;

    dq_pkg::word_t          cell_data  [DEPTH];
    logic [DEPTH-1:0]       cell_valid;
    dq_pkg::word_t          cell_tap   [DEPTH];
    dq_pkg::word_t          rear_acc;
    dq_pkg::word_t          front_sel;

    // handshake
    assign in_ready = !eval_reg && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;
    assign full     = (fill_reg == CNT_W'(DEPTH));
    assign is_empty = (fill_reg == '0);

    // operation decode
    always_comb
    begin
        ctrl        = '0;
        status_next = dq_pkg::ST_DONE;
        fill_next   = fill_reg;
        unique case (kind) inside
            dq_pkg::KIND_PUSH_FRONT, dq_pkg::KIND_PUSH_REAR:
            begin
                if (full)
                begin
                    status_next = dq_pkg::ST_OVER;
                end
                else
                begin
                    ctrl.push_front = accept && (kind == dq_pkg::KIND_PUSH_FRONT);
                    ctrl.push_rear  = accept && (kind == dq_pkg::KIND_PUSH_REAR);
                    fill_next       = fill_reg + 1'b1;
                end
            end
            dq_pkg::KIND_POP_FRONT, dq_pkg::KIND_POP_REAR:
            begin
                if (is_empty)
                begin
                    status_next = dq_pkg::ST_UNDER;
                end
                else
                begin
                    ctrl.pop_front = accept && (kind == dq_pkg::KIND_POP_FRONT);
                    ctrl.pop_rear  = accept && (kind == dq_pkg::KIND_POP_REAR);
                    fill_next      = fill_reg - 1'b1;
                end
            end
            default:
            begin
                status_next = dq_pkg::ST_DONE;
            end
        endcase
    end

    // cell chain; cell 0 sees an always-valid left boundary carrying the pushed word
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        dq_pkg::word_t l_data;
        logic          l_valid;
        dq_pkg::word_t r_data;
        logic          r_valid;

        if (i == 0)
        begin : g_first
            assign l_data  = value;
            assign l_valid = 1'b1;
        end
        else
        begin : g_mid_l
            assign l_data  = cell_data[i-1];
            assign l_valid = cell_valid[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign r_data  = '0;
            assign r_valid = 1'b0;
        end
        else
        begin : g_mid_r
            assign r_data  = cell_data[i+1];
            assign r_valid = cell_valid[i+1];
        end

        dq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .value       (value),
            .left_data   (l_data),
            .left_valid  (l_valid),
            .right_data  (r_data),
            .right_valid (r_valid),
            .data        (cell_data[i]),
            .valid       (cell_valid[i]),
            .rear_tap    (cell_tap[i])
        );
    end

    // end words: front sits in cell 0, rear is the OR of the taps, where only the rear cell's can be nonzero
    always_comb
    begin
        rear_acc = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rear_acc = rear_acc | cell_tap[i];
        end
    end

    assign front_sel = cell_valid[0] ? cell_data[0] : '0;

    // control registers
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (eval_reg)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            eval_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                fill_reg <= fill_next;
            end
            eval_reg      <= accept;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_status_reg <= status_next;
        end
        if (eval_reg)
        begin
            status_reg   <= pend_status_reg;
            front_reg    <= front_sel;
            rear_reg     <= rear_acc;
            fill_out_reg <= fill_reg;
        end
    end

    assign fill_wide  = {{dq_pkg::COUNT_W{1'b0}}, fill_out_reg};
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign front_word = front_reg;
    assign rear_word  = rear_reg;
    assign count      = fill_wide[dq_pkg::COUNT_W-1:0];
    assign empty_res  = (fill_out_reg == '0);

    // checks
    a_fill_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == 32'(fill_reg))
        else $error("fill count differs from number of valid cells");

    a_cells_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        ((cell_valid >> 1) & ~cell_valid) == '0)
        else $error("valid cells not packed from the front");

    a_eval_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        eval_reg |=> out_valid_reg)
        else $error("result not presented after evaluation");

    a_overflow_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == dq_pkg::ST_OVER) |-> fill_out_reg == CNT_W'(DEPTH))
        else $error("overflow reported on a queue that is not full");

    a_no_accept_while_eval: assert property (@(posedge clk) disable iff (!rst_n)
        eval_reg |-> !in_ready)
        else $error("input taken during evaluation");

endmodule

`default_nettype wire

### tb/dq_checker.sv
// ----------------------------------------------------------------------------
// dq_checker: result predictor and scoreboard for double_ended_queue
// Watches both channels, runs its own ring-buffer deque on every accepted
// operation and compares each accepted result, field by field, in order.
// ----------------------------------------------------------------------------
module dq_checker #(
    parameter int DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  dq_pkg::kind_t              kind,
    input  dq_pkg::word_t              value,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  dq_pkg::status_t            status,
    input  dq_pkg::word_t              front_word,
    input  dq_pkg::word_t              rear_word,
    input  logic [dq_pkg::COUNT_W-1:0] count,
    input  logic                       empty_res,
    output int                         fail_count,
    output int                         outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        dq_pkg::status_t            status;
        dq_pkg::word_t              front;
        dq_pkg::word_t              rear;
        logic [dq_pkg::COUNT_W-1:0] count;
        logic                       empty;
    } deque_view_t;

    // shadow deque: ring of words, front slot, slot past the rear, fill level
    dq_pkg::word_t ring [DEPTH];
    int            head_slot  = 0;
    int            tail_slot  = 0;
    int            fill_level = 0;
    deque_view_t   expected_views [$];
    int            mismatches = 0;

    assign fail_count = mismatches;

    function automatic int slot_after(int i);
        return (i + 1 >= DEPTH) ? 0 : i + 1;
    endfunction

    function automatic int slot_before(int i);
        return (i == 0) ? DEPTH - 1 : i - 1;
    endfunction

    // apply one operation to the shadow deque, return the view after it
    function automatic deque_view_t apply_deque_op(dq_pkg::kind_t op, dq_pkg::word_t data);
        deque_view_t v;
        v.status = dq_pkg::ST_DONE;
        if (op == dq_pkg::KIND_PUSH_FRONT || op == dq_pkg::KIND_PUSH_REAR) begin
            if (fill_level >= DEPTH) begin
                v.status = dq_pkg::ST_OVER;
            end
            else if (op == dq_pkg::KIND_PUSH_FRONT) begin
                head_slot = slot_before(head_slot);
                ring[head_slot] = data;
                fill_level++;
            end
            else begin
                ring[tail_slot] = data;
                tail_slot = slot_after(tail_slot);
                fill_level++;
            end
        end
        else begin
            if (fill_level == 0) begin
                v.status = dq_pkg::ST_UNDER;
            end
            else if (op == dq_pkg::KIND_POP_FRONT) begin
                head_slot = slot_after(head_slot);
                fill_level--;
            end
            else begin
                tail_slot = slot_before(tail_slot);
                fill_level--;
            end
        end
        // both ends read zero when nothing is stored
        v.front = (fill_level != 0) ? ring[head_slot] : '0;
        v.rear  = (fill_level != 0) ? ring[slot_before(tail_slot)] : '0;
        v.count = dq_pkg::COUNT_W'(fill_level);
        v.empty = (fill_level == 0);
        return v;
    endfunction

    // sample both channels at the edge where transactions complete
    always @(posedge clk) begin
        deque_view_t exp_v;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_views.size() == 0) begin
                    $error("result transaction with no operation pending");
                    mismatches++;
                end
                else begin
                    exp_v = expected_views.pop_front();
                    if (status !== exp_v.status) begin
                        $error("status: expected %0d, got %0d", exp_v.status, status);
                        mismatches++;
                    end
                    if (front_word !== exp_v.front) begin
                        $error("front_word: expected %0d, got %0d", exp_v.front, front_word);
                        mismatches++;
                    end
                    if (rear_word !== exp_v.rear) begin
                        $error("rear_word: expected %0d, got %0d", exp_v.rear, rear_word);
                        mismatches++;
                    end
                    if (count !== exp_v.count) begin
                        $error("count: expected %0d, got %0d", exp_v.count, count);
                        mismatches++;
                    end
                    if (empty_res !== exp_v.empty) begin
                        $error("empty_res: expected %0b, got %0b", exp_v.empty, empty_res);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready) begin
                expected_views.push_back(apply_deque_op(kind, value));
            end
            outstanding <= expected_views.size();
        end
    end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top level for double_ended_queue verification
// Drives operation transactions with random gaps and a randomly stalling
// result side; the checker predicts and compares, this module gives the
// verdict.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 16;
    localparam int RANDOM_OPS  = 1200;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_ready;
    dq_pkg::kind_t              kind      = dq_pkg::KIND_PUSH_REAR;
    dq_pkg::word_t              value     = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    dq_pkg::status_t            status;
    dq_pkg::word_t              front_word;
    dq_pkg::word_t              rear_word;
    logic [dq_pkg::COUNT_W-1:0] count;
    logic                       empty_res;
    int                         fail_count;
    int                         outstanding;

    // send-side burst length and result-side stall hold
    int                 burst_left = 0;
    int                 ready_hold = 0;

    always #1 clk = ~clk;

    double_ended_queue #(.DEPTH(DEPTH)) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .front_word (front_word),
        .rear_word  (rear_word),
        .count      (count),
        .empty_res  (empty_res)
    );

    dq_checker #(.DEPTH(DEPTH)) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .front_word (front_word),
        .rear_word  (rear_word),
        .count      (count),
        .empty_res  (empty_res),
        .fail_count (fail_count),
        .outstanding(outstanding)
    );

    // result side: ready held for random stretches, mostly short stalls
    always @(posedge clk) begin
        int r;
        if (ready_hold > 0) begin
            ready_hold--;
        end
        else begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                out_ready  <= 1'b1;
                ready_hold = $urandom_range(0, 8);
            end
            else if (r < 55) begin
                out_ready  <= 1'b1;
                ready_hold = $urandom_range(30, 80);
            end
            else if (r < 93) begin
                out_ready  <= 1'b0;
                ready_hold = $urandom_range(0, 3);
            end
            else begin
                out_ready  <= 1'b0;
                ready_hold = $urandom_range(10, 40);
            end
        end
    end

    // idle cycles after a transaction: bursts with none, mostly short, few long
    function automatic int pick_send_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 6) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // push words: extremes and small values mixed in with full-range ones
    function automatic dq_pkg::word_t pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return '1;
            4:       return dq_pkg::word_t'($urandom_range(0, 255));
            default: return dq_pkg::word_t'($urandom());
        endcase
    endfunction

    // one operation transaction; called at a rising edge
    task automatic issue_op(input dq_pkg::kind_t op, input dq_pkg::word_t data);
        int gap;
        in_valid <= 1'b1;
        kind     <= op;
        value    <= data;
        do @(posedge clk); while (!in_ready);
        gap = pick_send_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stimulus and verdict
    initial begin
        int push_pct;
        int phase_left;
        dq_pkg::kind_t op;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: underflow at both ends on the empty queue
        issue_op(dq_pkg::KIND_POP_FRONT, dq_pkg::word_t'($urandom()));
        issue_op(dq_pkg::KIND_POP_REAR, dq_pkg::word_t'($urandom()));
        // word extremes, then removing the last word from the front
        issue_op(dq_pkg::KIND_PUSH_FRONT, 32'sh7fff_ffff);
        issue_op(dq_pkg::KIND_PUSH_REAR, 32'sh8000_0000);
        issue_op(dq_pkg::KIND_POP_FRONT, '0);
        issue_op(dq_pkg::KIND_POP_FRONT, '0);
        // removing the last word from the rear
        issue_op(dq_pkg::KIND_PUSH_REAR, '1);
        issue_op(dq_pkg::KIND_POP_REAR, '1);
        // fill from both ends, then overflow at both ends
        for (int i = 0; i < DEPTH; i++) begin
            issue_op((i % 2 == 0) ? dq_pkg::KIND_PUSH_FRONT : dq_pkg::KIND_PUSH_REAR,
                     pick_word());
        end
        issue_op(dq_pkg::KIND_PUSH_FRONT, 32'sh1234_5678);
        issue_op(dq_pkg::KIND_PUSH_REAR, 32'sh8765_4321);

        // random: phases biased toward filling or draining so that full and
        // empty are reached often
        phase_left = 0;
        push_pct   = 50;
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(20, 60);
                case ($urandom_range(0, 4))
                    0:       push_pct = 5;
                    1:       push_pct = 25;
                    2:       push_pct = 50;
                    3:       push_pct = 75;
                    default: push_pct = 95;
                endcase
            end
            phase_left--;
            if ($urandom_range(0, 99) < push_pct)
                op = ($urandom_range(0, 1) != 0) ? dq_pkg::KIND_PUSH_FRONT
                                                 : dq_pkg::KIND_PUSH_REAR;
            else
                op = ($urandom_range(0, 1) != 0) ? dq_pkg::KIND_POP_FRONT
                                                 : dq_pkg::KIND_POP_REAR;
            issue_op(op, pick_word());
        end
        in_valid <= 1'b0;

        // drain, then allow for the result latency and more
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0 && outstanding == 0) begin
            $display("double_ended_queue verification clean");
        end
        else begin
            $display("double_ended_queue verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #1_000_000;
        $display("double_ended_queue verification failed");
        $finish;
    end

endmodule

### filelist.f
design/dq_pkg.sv
design/dq_cell.sv
design/double_ended_queue.sv
tb/dq_checker.sv
tb/testbench.sv
